>>> design/tdq_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and helpers for the timer delay queue.
// Depends on nothing; the sequencer, top level and port checks refer to it by scoped names.
package tdq_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int ID_BITS     = 8;
    localparam int ID_W        = 8;
    localparam int TIME_W      = 32;
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int Q_IDX_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int ENTRY_W     = TIME_W + ID_BITS;

    localparam logic [Q_CNT_W:0]   DEPTH_EXT = QUEUE_DEPTH[Q_CNT_W:0];
    localparam logic [Q_CNT_W-1:0] DEPTH_CNT = QUEUE_DEPTH[Q_CNT_W-1:0];
    localparam logic [Q_IDX_W-1:0] LAST_IDX  = Q_IDX_W'(QUEUE_DEPTH - 1);

    localparam logic [1:0] ACT_QUERY = 2'd0;
    localparam logic [1:0] ACT_REL   = 2'd1;
    localparam logic [1:0] ACT_ABS   = 2'd2;
    localparam logic [1:0] ACT_TICK  = 2'd3;

    localparam logic [1:0] KIND_TIME  = 2'd0;
    localparam logic [1:0] KIND_WOKEN = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;
    localparam logic [1:0] KIND_FULL  = 2'd3;

    typedef struct packed {
        logic [1:0]        action;
        logic [ID_W-1:0]   requester_id;
        logic [TIME_W-1:0] delay_ticks;
    } t_in_word;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ID_W-1:0]   task_id;
        logic [TIME_W-1:0] current_time;
        logic              last;
    } t_out_word;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EMIT,
        ST_INS_RD,
        ST_INS_CMP,
        ST_INS_PUT,
        ST_REL_RD,
        ST_REL_CMP
    } t_state;

    typedef enum logic [1:0] {
        RD_J1,
        RD_J2,
        RD_HEAD
    } t_rd_sel;

    typedef struct packed {
        logic       fire;
        logic [1:0] action;
        logic       full;
        logic       empty;
        logic       gt;
        logic       j_one;
        logic       out_free;
    } t_sts;

    typedef struct packed {
        logic    ready;
        t_rd_sel rd_sel;
        logic    wr_en;
        logic    wr_new;
        logic    j_dec;
        logic    cnt_inc;
        logic    pop;
        logic    emit;
    } t_ctl;

    // Maps a queue position, counted from the head, to a RAM address.
    function automatic logic [Q_IDX_W-1:0] f_wrap(input logic [Q_IDX_W-1:0] base,
                                                  input logic [Q_CNT_W-1:0] off);
        logic [Q_CNT_W:0] s;
        s = (Q_CNT_W + 1)'(base) + {1'b0, off};
        if (s >= DEPTH_EXT) begin
            s = s - DEPTH_EXT;
        end
        return s[Q_IDX_W-1:0];
    endfunction

endpackage

>>> design/tdq_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module tdq_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> design/tdq_seq.sv
`timescale 1ns / 1ps
// Sequencer of the timer delay queue: steps insertion and release walks.
// Depends on tdq_pkg for the state, status and control types.
module tdq_seq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  tdq_pkg::t_sts i_sts,
    output tdq_pkg::t_ctl o_ctl
);

    tdq_pkg::t_state r_state;
    tdq_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tdq_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tdq_pkg::ST_IDLE: begin
                if (i_sts.fire) begin
                    unique case (i_sts.action)
                        tdq_pkg::ACT_QUERY: n_state = tdq_pkg::ST_EMIT;
                        tdq_pkg::ACT_REL,
                        tdq_pkg::ACT_ABS: begin
                            priority if (i_sts.full) begin
                                n_state = tdq_pkg::ST_EMIT;
                            end else if (i_sts.empty) begin
                                n_state = tdq_pkg::ST_INS_PUT;
                            end else begin
                                n_state = tdq_pkg::ST_INS_RD;
                            end
                        end
                        default: n_state = tdq_pkg::ST_REL_RD;
                    endcase
                end
            end
            tdq_pkg::ST_INS_RD: n_state = tdq_pkg::ST_INS_CMP;
            tdq_pkg::ST_INS_CMP: begin
                priority if (!i_sts.gt) begin
                    n_state = tdq_pkg::ST_IDLE;
                end else if (i_sts.j_one) begin
                    n_state = tdq_pkg::ST_INS_PUT;
                end else begin
                    n_state = tdq_pkg::ST_INS_CMP;
                end
            end
            tdq_pkg::ST_INS_PUT: n_state = tdq_pkg::ST_IDLE;
            tdq_pkg::ST_REL_RD: begin
                n_state = i_sts.empty ? tdq_pkg::ST_EMIT : tdq_pkg::ST_REL_CMP;
            end
            tdq_pkg::ST_REL_CMP: begin
                priority if (i_sts.gt) begin
                    n_state = tdq_pkg::ST_EMIT;
                end else if (i_sts.out_free) begin
                    n_state = tdq_pkg::ST_REL_RD;
                end else begin
                    n_state = tdq_pkg::ST_REL_CMP;
                end
            end
            tdq_pkg::ST_EMIT: begin
                if (i_sts.out_free) begin
                    n_state = tdq_pkg::ST_IDLE;
                end
            end
            default: n_state = tdq_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_ctl         = '0;
        o_ctl.rd_sel  = tdq_pkg::RD_HEAD;
        unique case (r_state)
            tdq_pkg::ST_IDLE: o_ctl.ready = 1'b1;
            tdq_pkg::ST_INS_RD: o_ctl.rd_sel = tdq_pkg::RD_J1;
            tdq_pkg::ST_INS_CMP: begin
                o_ctl.rd_sel  = tdq_pkg::RD_J2;
                o_ctl.wr_en   = 1'b1;
                o_ctl.wr_new  = !i_sts.gt;
                o_ctl.j_dec   = i_sts.gt;
                o_ctl.cnt_inc = !i_sts.gt;
            end
            tdq_pkg::ST_INS_PUT: begin
                o_ctl.wr_en   = 1'b1;
                o_ctl.wr_new  = 1'b1;
                o_ctl.cnt_inc = 1'b1;
            end
            tdq_pkg::ST_REL_RD: o_ctl.rd_sel = tdq_pkg::RD_HEAD;
            tdq_pkg::ST_REL_CMP: o_ctl.pop = !i_sts.gt && i_sts.out_free;
            tdq_pkg::ST_EMIT: o_ctl.emit = i_sts.out_free;
            default: o_ctl.ready = 1'b0;
        endcase
    end

endmodule

>>> design/timer_delay_queue.sv
`timescale 1ns / 1ps
// Timer delay queue top level: tick counter, wake-time ordered sleeper queue, output register.
// Depends on tdq_pkg, tdq_ram and tdq_seq.
//
// The block takes one word at a time and holds o_in_stall high until that word's work is done.
// A time query or a rejected delay goes straight to the emit state, where it waits out any
// output stall. A delay that is queued is written at once into an empty queue; otherwise the
// queued entries are read from the tail, each with a later wake time moves up one place, and
// the delay is written where the walk stops. A tick reads the head, releases each woken
// requester in turn, waiting out output stalls, and then emits its done word. The queue lives
// in a RAM with one write and one registered read port, and a single comparator checks the
// entries one at a time. The queue needs no clearing after reset.
module timer_delay_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  tdq_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output tdq_pkg::t_out_word o_out_word
);

    tdq_pkg::t_sts sts;
    tdq_pkg::t_ctl ctl;

    logic [tdq_pkg::TIME_W-1:0]  r_time;
    logic [tdq_pkg::TIME_W-1:0]  r_key;
    logic [tdq_pkg::ID_BITS-1:0] r_id;
    logic [1:0]                  r_kind;
    logic [tdq_pkg::Q_CNT_W-1:0] r_count;
    logic [tdq_pkg::Q_CNT_W-1:0] r_j;
    logic [tdq_pkg::Q_IDX_W-1:0] r_head;
    logic                        r_out_valid;
    tdq_pkg::t_out_word          r_out_word;

    logic                         accept;
    logic                         out_free;
    logic [tdq_pkg::TIME_W-1:0]   addend;
    logic [tdq_pkg::TIME_W:0]     sum;
    logic [tdq_pkg::TIME_W-1:0]   sat_sum;
    logic [tdq_pkg::Q_IDX_W-1:0]  rd_addr;
    logic [tdq_pkg::Q_IDX_W-1:0]  wr_addr;
    logic [tdq_pkg::ENTRY_W-1:0]  wr_data;
    logic [tdq_pkg::ENTRY_W-1:0]  rd_data;
    logic [tdq_pkg::TIME_W-1:0]   rd_wake;
    logic [tdq_pkg::ID_BITS-1:0]  rd_id;
    logic [tdq_pkg::TIME_W-1:0]   cmp_key;

    assign accept   = i_in_valid && ctl.ready;
    assign out_free = !r_out_valid || !i_out_stall;

    assign addend  = (i_in_word.action == tdq_pkg::ACT_TICK) ? tdq_pkg::TIME_W'(1)
                                                              : i_in_word.delay_ticks;
    assign sum     = {1'b0, r_time} + {1'b0, addend};
    assign sat_sum = sum[tdq_pkg::TIME_W] ? '1 : sum[tdq_pkg::TIME_W-1:0];

    assign rd_wake = rd_data[tdq_pkg::ENTRY_W-1:tdq_pkg::ID_BITS];
    assign rd_id   = rd_data[tdq_pkg::ID_BITS-1:0];
    assign cmp_key = (ctl.rd_sel == tdq_pkg::RD_HEAD) ? r_time : r_key;

    always_comb begin
        unique case (ctl.rd_sel)
            tdq_pkg::RD_J1:   rd_addr = tdq_pkg::f_wrap(r_head, r_j - 1'b1);
            tdq_pkg::RD_J2:   rd_addr = tdq_pkg::f_wrap(r_head, r_j - 2'd2);
            tdq_pkg::RD_HEAD: rd_addr = r_head;
            default:          rd_addr = r_head;
        endcase
    end

    assign wr_addr = tdq_pkg::f_wrap(r_head, r_j);
    assign wr_data = ctl.wr_new ? {r_key, r_id} : rd_data;

    assign sts.fire     = accept;
    assign sts.action   = i_in_word.action;
    assign sts.full     = (r_count == tdq_pkg::DEPTH_CNT);
    assign sts.empty    = (r_count == '0);
    assign sts.gt       = (rd_wake > cmp_key);
    assign sts.j_one    = (r_j == tdq_pkg::Q_CNT_W'(1));
    assign sts.out_free = out_free;

    tdq_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_ctl   (ctl)
    );

    tdq_ram #(
        .WIDTH (tdq_pkg::ENTRY_W),
        .DEPTH (tdq_pkg::QUEUE_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ctl.wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time      <= '0;
            r_count     <= '0;
            r_head      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept && (i_in_word.action == tdq_pkg::ACT_TICK)) begin
                r_time <= sat_sum;
            end
            if (ctl.cnt_inc) begin
                r_count <= r_count + 1'b1;
            end else if (ctl.pop) begin
                r_count <= r_count - 1'b1;
            end
            if (ctl.pop) begin
                r_head <= (r_head == tdq_pkg::LAST_IDX) ? '0 : r_head + 1'b1;
            end
            if (ctl.emit || ctl.pop) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_id <= i_in_word.requester_id[tdq_pkg::ID_BITS-1:0];
            r_j  <= r_count;
            r_key <= (i_in_word.action == tdq_pkg::ACT_REL) ? sat_sum
                                                             : i_in_word.delay_ticks;
            unique case (i_in_word.action)
                tdq_pkg::ACT_QUERY: r_kind <= tdq_pkg::KIND_TIME;
                tdq_pkg::ACT_REL,
                tdq_pkg::ACT_ABS:   r_kind <= tdq_pkg::KIND_FULL;
                default:            r_kind <= tdq_pkg::KIND_TICK;
            endcase
        end else if (ctl.j_dec) begin
            r_j <= r_j - 1'b1;
        end
        if (ctl.pop) begin
            r_out_word.kind         <= tdq_pkg::KIND_WOKEN;
            r_out_word.task_id      <= tdq_pkg::ID_W'(rd_id);
            r_out_word.current_time <= r_time;
            r_out_word.last         <= 1'b0;
        end else if (ctl.emit) begin
            r_out_word.kind         <= r_kind;
            r_out_word.task_id      <= tdq_pkg::ID_W'(r_id);
            r_out_word.current_time <= r_time;
            r_out_word.last         <= 1'b1;
        end
    end

    assign o_in_stall  = !ctl.ready;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

>>> design/tdq_chk.sv
`timescale 1ns / 1ps
// Port-level checks for the timer delay queue, bound to the top level.
// Depends on tdq_pkg and timer_delay_queue.
module tdq_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input tdq_pkg::t_in_word  i_in_word,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input tdq_pkg::t_out_word o_out_word
);

    logic in_acc;
    assign in_acc = i_in_valid && !o_in_stall;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("Stalled output word changed.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("Block took a word without going busy.");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_word.kind == tdq_pkg::KIND_WOKEN) != o_out_word.last))
        else $error("Last flag does not match result kind.");

    a_tick_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_word.kind == tdq_pkg::KIND_TICK) |->
            (o_out_word.current_time != '0))
        else $error("Tick done reported a zero count.");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("Output valid after reset.");

endmodule

bind timer_delay_queue tdq_chk u_tdq_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_word   (i_in_word),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);

>>> tb/tdq_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the timer delay queue: watches both word channels, keeps its own tick count
// and sleeper queue, predicts every result word and compares it field by field.
// Depends on tdq_pkg.
module tdq_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  tdq_pkg::t_in_word  i_in_word,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  tdq_pkg::t_out_word i_out_word,
    output int                 o_fail_count,
    output int                 o_pending
);
    import tdq_pkg::*;

    localparam logic [ID_W-1:0]   ID_MASK  = ID_W'((1 << ID_BITS) - 1);
    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    logic [TIME_W-1:0] now_ticks;
    logic [TIME_W-1:0] sleep_wake [QUEUE_DEPTH];
    logic [ID_W-1:0]   sleep_id   [QUEUE_DEPTH];
    int                sleep_cnt;
    t_out_word         timer_replies [$];
    int                fail_count = 0;

    function automatic t_out_word make_reply(input logic [1:0] kind,
                                             input logic [ID_W-1:0] id,
                                             input logic [TIME_W-1:0] stamp,
                                             input logic last);
        t_out_word r;
        r.kind         = kind;
        r.task_id      = id;
        r.current_time = stamp;
        r.last         = last;
        return r;
    endfunction

    task automatic queue_sleeper(input logic [TIME_W-1:0] wake, input logic [ID_W-1:0] id);
        int pos;
        if (sleep_cnt >= QUEUE_DEPTH) begin
            timer_replies.push_back(make_reply(KIND_FULL, id, now_ticks, 1'b1));
        end else begin
            pos = 0;
            while (pos < sleep_cnt && sleep_wake[pos] <= wake) begin
                pos++;
            end
            for (int i = sleep_cnt; i > pos; i--) begin
                sleep_wake[i] = sleep_wake[i-1];
                sleep_id[i]   = sleep_id[i-1];
            end
            sleep_wake[pos] = wake;
            sleep_id[pos]   = id;
            sleep_cnt++;
        end
    endtask

    task automatic timer_step(input t_in_word w);
        logic [ID_W-1:0] id;
        logic [TIME_W:0] wake_sum;
        int              woken;
        id = w.requester_id & ID_MASK;
        case (w.action)
            ACT_QUERY: begin
                timer_replies.push_back(make_reply(KIND_TIME, id, now_ticks, 1'b1));
            end
            ACT_REL: begin
                wake_sum = {1'b0, now_ticks} + {1'b0, w.delay_ticks};
                queue_sleeper(wake_sum[TIME_W] ? TIME_MAX : wake_sum[TIME_W-1:0], id);
            end
            ACT_ABS: begin
                queue_sleeper(w.delay_ticks, id);
            end
            default: begin
                if (now_ticks != TIME_MAX) begin
                    now_ticks++;
                end
                woken = 0;
                while (woken < sleep_cnt && sleep_wake[woken] <= now_ticks) begin
                    timer_replies.push_back(make_reply(KIND_WOKEN, sleep_id[woken],
                                                       now_ticks, 1'b0));
                    woken++;
                end
                for (int i = woken; i < sleep_cnt; i++) begin
                    sleep_wake[i-woken] = sleep_wake[i];
                    sleep_id[i-woken]   = sleep_id[i];
                end
                sleep_cnt -= woken;
                timer_replies.push_back(make_reply(KIND_TICK, id, now_ticks, 1'b1));
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            now_ticks = '0;
            sleep_cnt = 0;
            timer_replies.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                timer_step(i_in_word);
            end
            if (i_out_valid && !i_out_stall) begin
                if (timer_replies.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("%0t: unexpected word kind=%0d id=%0h time=%0h last=%0d", $time,
                                 i_out_word.kind, i_out_word.task_id,
                                 i_out_word.current_time, i_out_word.last);
                    end
                end else begin
                    want = timer_replies.pop_front();
                    if (i_out_word.kind !== want.kind || i_out_word.task_id !== want.task_id ||
                        i_out_word.current_time !== want.current_time ||
                        i_out_word.last !== want.last) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("%0t: word mismatch exp kind=%0d id=%0h time=%0h last=%0d",
                                     $time, want.kind, want.task_id, want.current_time,
                                     want.last);
                            $display("%0t:               got kind=%0d id=%0h time=%0h last=%0d",
                                     $time, i_out_word.kind, i_out_word.task_id,
                                     i_out_word.current_time, i_out_word.last);
                        end
                    end
                end
            end
        end
        o_fail_count = fail_count;
        o_pending    = timer_replies.size();
    end

endmodule

>>> tb/tb_timer_delay_queue.sv
`timescale 1ns / 1ps
// Testbench top for the timer delay queue: clock, reset, directed and random request words,
// random idling on both channels and the final verdict.
// Depends on tdq_pkg, timer_delay_queue and tdq_checker.
module tb_timer_delay_queue;
    import tdq_pkg::*;

    localparam int RANDOM_WORDS = 170;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_word  in_word;
    logic      out_valid;
    logic      out_stall;
    t_out_word out_word;
    int        fail_count;
    int        pending;
    bit        calm;
    int        sent;
    int        burst_cnt;
    bit        drained;

    timer_delay_queue u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word)
    );

    tdq_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_word   (out_word),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial begin
        #2_000_000;
        $display("timer_delay_queue verification failed");
        $finish;
    end

    always @(negedge clk) begin
        out_stall <= !calm && ($urandom_range(0, 99) < 27);
    end

    task automatic send_word(input logic [1:0] act, input logic [ID_W-1:0] rid,
                             input logic [TIME_W-1:0] ticks);
        t_in_word w;
        w.action       = act;
        w.requester_id = rid;
        w.delay_ticks  = ticks;
        while (!calm && $urandom_range(0, 99) < 27) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        @(negedge clk);
        sent++;
    endtask

    task automatic drain_replies();
        in_valid <= 1'b0;
        while (pending != 0) begin
            @(negedge clk);
        end
    endtask

    function automatic logic [TIME_W-1:0] rand_span();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
            return TIME_W'($urandom_range(0, 12));
        end else if (pick < 85) begin
            return '1;
        end else if (pick < 92) begin
            return '0;
        end
        return TIME_W'($urandom);
    endfunction

    function automatic logic [TIME_W-1:0] rand_wake();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
            return TIME_W'($urandom_range(0, 150));
        end else if (pick < 90) begin
            return '0;
        end else if (pick < 95) begin
            return '1;
        end
        return TIME_W'($urandom);
    endfunction

    task automatic send_random();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            send_word(ACT_QUERY, ID_W'($urandom), TIME_W'($urandom));
        end else if (pick < 50) begin
            send_word(ACT_REL, ID_W'($urandom), rand_span());
        end else if (pick < 70) begin
            send_word(ACT_ABS, ID_W'($urandom), rand_wake());
        end else begin
            send_word(ACT_TICK, ID_W'($urandom), TIME_W'($urandom));
        end
    endtask

    initial begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_word   = '0;
        calm      = 1'b0;
        sent      = 0;
        burst_cnt = 0;
        drained   = 1'b0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_word(ACT_QUERY, 8'h00, 32'h0000_0000);
        send_word(ACT_QUERY, 8'hFF, 32'hFFFF_FFFF);
        send_word(ACT_ABS,   8'h01, 32'h0000_0000);
        send_word(ACT_REL,   8'h02, 32'h0000_0000);
        send_word(ACT_TICK,  8'hAA, 32'h0000_0000);
        send_word(ACT_REL,   8'h10, 32'h0000_0003);
        send_word(ACT_ABS,   8'h11, 32'h0000_0004);
        send_word(ACT_REL,   8'h12, 32'h0000_0003);
        send_word(ACT_ABS,   8'h20, 32'hFFFF_FFFF);
        send_word(ACT_REL,   8'h21, 32'hFFFF_FFFF);
        send_word(ACT_REL,   8'h22, 32'h8000_0000);
        send_word(ACT_TICK,  8'h55, 32'hFFFF_FFFF);
        send_word(ACT_TICK,  8'h00, 32'h1234_5678);
        send_word(ACT_TICK,  8'hFF, 32'h0000_0000);
        send_word(ACT_QUERY, 8'h5A, 32'h5555_5555);
        send_word(ACT_ABS,   8'hA5, 32'hAAAA_AAAA);
        send_word(ACT_REL,   8'h7F, 32'h0000_0001);
        send_word(ACT_TICK,  8'h80, 32'h0000_0000);
        drain_replies();

        sent = 0;
        while (sent < RANDOM_WORDS) begin
            calm = (sent >= 70 && sent < 115);
            if (burst_cnt == 0 || $urandom_range(0, 9) == 0) begin
                // More delays than the queue holds, so the tail of the burst is rejected.
                repeat (36) begin
                    if ($urandom_range(0, 1) == 1) begin
                        send_word(ACT_REL, ID_W'($urandom), TIME_W'($urandom_range(1, 30)));
                    end else begin
                        send_word(ACT_ABS, ID_W'($urandom), TIME_W'($urandom_range(0, 200)));
                    end
                end
                repeat (20) send_word(ACT_TICK, ID_W'($urandom), TIME_W'($urandom));
                burst_cnt++;
            end else begin
                send_random();
            end
            if (!drained && sent >= 100) begin
                drain_replies();
                drained = 1'b1;
            end
        end

        calm = 1'b0;
        in_valid <= 1'b0;
        drain_replies();
        repeat (100) @(negedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("timer_delay_queue verification clean");
        end else begin
            $display("timer_delay_queue verification failed");
        end
        $finish;
    end

endmodule
